[design/rlsc_pkg.sv]
// ----------------------------------------------------------------------------
// rlsc_pkg
// shared types, register indexes and reset values of the rear light signal
// controller
// ----------------------------------------------------------------------------
package rlsc_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int DUTY_BITS_DEF = 8;

  localparam int IN_TIME_W = 32;
  localparam int TICKS_W   = 16;
  localparam int DUTY_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOCKOUT      = 3'd0,
    REG_PULSE_ON     = 3'd1,
    REG_PULSE_PERIOD = 3'd2,
    REG_FLASH_HALF   = 3'd3,
    REG_DUTY_FULL    = 3'd4,
    REG_DUTY_HALF    = 3'd5
  } cfg_idx_t;

  localparam logic [TICKS_W-1:0] LOCKOUT_RST      = 16'd50;
  localparam logic [TICKS_W-1:0] PULSE_ON_RST     = 16'd10;
  localparam logic [TICKS_W-1:0] PULSE_PERIOD_RST = 16'd1000;
  localparam logic [TICKS_W-1:0] FLASH_HALF_RST   = 16'd333;
  localparam logic [DUTY_W-1:0]  DUTY_FULL_RST    = 8'd255;
  localparam logic [DUTY_W-1:0]  DUTY_HALF_RST    = 8'd127;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_LEFT  = 2'd1,
    MODE_RIGHT = 2'd2
  } mode_t;

  typedef struct packed {
    logic [TICKS_W-1:0] lockout;
    logic [TICKS_W-1:0] pulse_on;
    logic [TICKS_W-1:0] pulse_period;
    logic [TICKS_W-1:0] flash_half;
    logic [DUTY_W-1:0]  duty_full;
    logic [DUTY_W-1:0]  duty_half;
  } cfg_t;

  typedef struct packed {
    logic read_ok;
    logic left_button;
    logic right_button;
    logic left_brake_on;
    logic right_brake_on;
  } switches_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_left;
    logic [DUTY_W-1:0] duty_right;
    logic              brake_active;
    mode_t             signal_mode;
  } result_t;

endpackage

[design/rlsc_in_if.sv]
// ----------------------------------------------------------------------------
// rlsc_in_if
// poll sample request channel
// ----------------------------------------------------------------------------
interface rlsc_in_if;
  logic                           valid;
  logic                           ready;
  logic [rlsc_pkg::IN_TIME_W-1:0] time_now;
  logic                           read_ok;
  logic                           left_button;
  logic                           right_button;
  logic                           left_brake_on;
  logic                           right_brake_on;

  modport source (
    output valid, time_now, read_ok, left_button, right_button,
           left_brake_on, right_brake_on,
    input  ready
  );
  modport sink (
    input  valid, time_now, read_ok, left_button, right_button,
           left_brake_on, right_brake_on,
    output ready
  );
endinterface

[design/rlsc_out_if.sv]
// ----------------------------------------------------------------------------
// rlsc_out_if
// lamp duty result channel
// ----------------------------------------------------------------------------
interface rlsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rlsc_pkg::DUTY_W-1:0] duty_left;
  logic [rlsc_pkg::DUTY_W-1:0] duty_right;
  logic                        brake_active;
  logic [1:0]                  signal_mode;

  modport source (
    output valid, duty_left, duty_right, brake_active, signal_mode,
    input  ready
  );
  modport sink (
    input  valid, duty_left, duty_right, brake_active, signal_mode,
    output ready
  );
endinterface

[design/rear_light_signal_controller_top.sv]
// ----------------------------------------------------------------------------
// rear_light_signal_controller_top
// turn signal, brake and running light duty controller for two rear lamps
// ----------------------------------------------------------------------------
// Takes one poll sample per clock cycle while results are being taken and
// returns one duty result per sample: the sample lands in an input register,
// one pass of compare and subtract logic on the timer state produces the
// result, and it is held in an output register until taken. Both registers
// stall independently, so a new sample is accepted while a finished result
// waits. Configuration writes take effect on the next sample and are meant to
// be made with no request in flight.
// ----------------------------------------------------------------------------
module rear_light_signal_controller_top #(
  parameter int TIME_BITS = rlsc_pkg::TIME_BITS_DEF,
  parameter int DUTY_BITS = rlsc_pkg::DUTY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rlsc_in_if.sink                         in_if,
  rlsc_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [rlsc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rlsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rlsc_pkg::cfg_t       cfg_r;
  logic                 in_valid_r, out_valid_r;
  logic [TIME_BITS-1:0] now_r;
  rlsc_pkg::switches_t  sw_r;
  rlsc_pkg::result_t    res_nxt, res_r;
  logic                 advance;

  assign advance      = in_valid_r & (~out_valid_r | out_if.ready);
  assign in_if.ready  = ~in_valid_r | advance;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lockout      <= rlsc_pkg::LOCKOUT_RST;
      cfg_r.pulse_on     <= rlsc_pkg::PULSE_ON_RST;
      cfg_r.pulse_period <= rlsc_pkg::PULSE_PERIOD_RST;
      cfg_r.flash_half   <= rlsc_pkg::FLASH_HALF_RST;
      cfg_r.duty_full    <= rlsc_pkg::DUTY_FULL_RST;
      cfg_r.duty_half    <= rlsc_pkg::DUTY_HALF_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        rlsc_pkg::REG_LOCKOUT:      cfg_r.lockout      <= cfg_wdata;
        rlsc_pkg::REG_PULSE_ON:     cfg_r.pulse_on     <= cfg_wdata;
        rlsc_pkg::REG_PULSE_PERIOD: cfg_r.pulse_period <= cfg_wdata;
        rlsc_pkg::REG_FLASH_HALF:   cfg_r.flash_half   <= cfg_wdata;
        rlsc_pkg::REG_DUTY_FULL:    cfg_r.duty_full    <= cfg_wdata[rlsc_pkg::DUTY_W-1:0];
        rlsc_pkg::REG_DUTY_HALF:    cfg_r.duty_half    <= cfg_wdata[rlsc_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      now_r             <= TIME_BITS'(in_if.time_now);
      sw_r.read_ok      <= in_if.read_ok;
      sw_r.left_button  <= in_if.left_button;
      sw_r.right_button <= in_if.right_button;
      sw_r.left_brake_on  <= in_if.left_brake_on;
      sw_r.right_brake_on <= in_if.right_brake_on;
    end
  end

  rlsc_core #(
    .TIME_BITS (TIME_BITS),
    .DUTY_BITS (DUTY_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .now     (now_r),
    .sw      (sw_r),
    .cfg     (cfg_r),
    .result  (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.duty_left    = res_r.duty_left;
  assign out_if.duty_right   = res_r.duty_right;
  assign out_if.brake_active = res_r.brake_active;
  assign out_if.signal_mode  = res_r.signal_mode;

endmodule

[design/rlsc_core.sv]
// ----------------------------------------------------------------------------
// rlsc_core
// button edge and lockout logic, pulse and flash timers, lamp priority
// ----------------------------------------------------------------------------
module rlsc_core #(
  parameter int TIME_BITS = rlsc_pkg::TIME_BITS_DEF,
  parameter int DUTY_BITS = rlsc_pkg::DUTY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic [TIME_BITS-1:0] now,
  input  rlsc_pkg::switches_t  sw,
  input  rlsc_pkg::cfg_t       cfg,
  output rlsc_pkg::result_t    result
);

  localparam logic [rlsc_pkg::DUTY_W-1:0] DUTY_MASK =
    (DUTY_BITS >= rlsc_pkg::DUTY_W) ? {rlsc_pkg::DUTY_W{1'b1}} :
    rlsc_pkg::DUTY_W'((1 << DUTY_BITS) - 1);

  logic                 prev_left_r, prev_right_r, flash_bright_r;
  logic [TIME_BITS-1:0] left_press_r, right_press_r, pulse_start_r, flash_start_r;
  rlsc_pkg::mode_t      mode_r;

  logic                 prev_left_nxt, prev_right_nxt, flash_bright_nxt;
  logic [TIME_BITS-1:0] left_press_nxt, right_press_nxt, pulse_start_nxt, flash_start_nxt;
  rlsc_pkg::mode_t      mode_nxt, mode_mid;

  logic                 lb, rb, brake;
  logic                 left_fire, right_fire, flash_restart, bright_mid, flash_toggle;
  logic                 pulse_in_on, pulse_restart, pulse_lit;
  logic [TIME_BITS-1:0] lockout_w, pulse_diff, flash_diff;
  logic [rlsc_pkg::DUTY_W-1:0] duty_l, duty_r;

  assign lb    = sw.read_ok & sw.left_button;
  assign rb    = sw.read_ok & sw.right_button;
  assign brake = sw.read_ok & (sw.left_brake_on | sw.right_brake_on);
  assign lockout_w = TIME_BITS'(cfg.lockout);

  always_comb begin
    left_fire  = lb & ~prev_left_r & ((now - left_press_r) > lockout_w);
    mode_mid   = mode_r;
    if (left_fire) begin
      mode_mid = (mode_r == rlsc_pkg::MODE_LEFT) ? rlsc_pkg::MODE_OFF : rlsc_pkg::MODE_LEFT;
    end
    right_fire = rb & ~prev_right_r & ((now - right_press_r) > lockout_w);
    mode_nxt   = mode_mid;
    if (right_fire) begin
      mode_nxt = (mode_mid == rlsc_pkg::MODE_RIGHT) ? rlsc_pkg::MODE_OFF : rlsc_pkg::MODE_RIGHT;
    end
    flash_restart = (left_fire & (mode_r != rlsc_pkg::MODE_LEFT)) |
                    (right_fire & (mode_mid != rlsc_pkg::MODE_RIGHT));

    prev_left_nxt   = lb;
    prev_right_nxt  = rb;
    left_press_nxt  = left_fire  ? now : left_press_r;
    right_press_nxt = right_fire ? now : right_press_r;

    pulse_diff      = now - pulse_start_r;
    pulse_in_on     = pulse_diff < TIME_BITS'(cfg.pulse_on);
    pulse_restart   = ~pulse_in_on & (pulse_diff >= TIME_BITS'(cfg.pulse_period));
    pulse_start_nxt = pulse_restart ? now : pulse_start_r;
    pulse_lit       = (pulse_in_on | pulse_restart) & (mode_nxt == rlsc_pkg::MODE_OFF);

    bright_mid       = flash_restart | flash_bright_r;
    flash_diff       = flash_restart ? '0 : (now - flash_start_r);
    flash_toggle     = flash_diff >= TIME_BITS'(cfg.flash_half);
    flash_bright_nxt = flash_toggle ? ~bright_mid : bright_mid;
    flash_start_nxt  = (flash_toggle | flash_restart) ? now : flash_start_r;

    if (mode_nxt == rlsc_pkg::MODE_LEFT) begin
      duty_l = flash_bright_nxt ? cfg.duty_full : '0;
    end else if (brake) begin
      duty_l = cfg.duty_full;
    end else if (pulse_lit) begin
      duty_l = cfg.duty_half;
    end else begin
      duty_l = '0;
    end
    if (mode_nxt == rlsc_pkg::MODE_RIGHT) begin
      duty_r = flash_bright_nxt ? cfg.duty_full : '0;
    end else if (brake) begin
      duty_r = cfg.duty_full;
    end else if (pulse_lit) begin
      duty_r = cfg.duty_half;
    end else begin
      duty_r = '0;
    end

    result.duty_left    = duty_l & DUTY_MASK;
    result.duty_right   = duty_r & DUTY_MASK;
    result.brake_active = brake;
    result.signal_mode  = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_left_r    <= 1'b0;
      prev_right_r   <= 1'b0;
      flash_bright_r <= 1'b0;
      left_press_r   <= '0;
      right_press_r  <= '0;
      pulse_start_r  <= '0;
      flash_start_r  <= '0;
      mode_r         <= rlsc_pkg::MODE_OFF;
    end else if (step_en) begin
      prev_left_r    <= prev_left_nxt;
      prev_right_r   <= prev_right_nxt;
      flash_bright_r <= flash_bright_nxt;
      left_press_r   <= left_press_nxt;
      right_press_r  <= right_press_nxt;
      pulse_start_r  <= pulse_start_nxt;
      flash_start_r  <= flash_start_nxt;
      mode_r         <= mode_nxt;
    end
  end

`ifndef SYNTHESIS
  a_restart_bright: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && flash_restart && (cfg.flash_half != '0) |=> flash_bright_r)
    else $error("flash restart did not leave the bright half");

  a_no_pulse_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (mode_nxt != rlsc_pkg::MODE_OFF) |-> !pulse_lit)
    else $error("running pulse lit while turn signal active");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(mode_r) && $stable(flash_start_r) && $stable(pulse_start_r))
    else $error("state moved without a request");

  a_mode_follows_fire: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !left_fire && !right_fire |=> $stable(mode_r))
    else $error("mode changed without an accepted press");
`endif

endmodule

[test/rear_light_signal_controller_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rear_light_signal_controller_checker
// Watches the poll sample and lamp duty channels and the register write port.
// Keeps its own copy of the turn signal, pulse and flash timer state, predicts
// the duty result of every accepted request, and compares each accepted
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rear_light_signal_controller_checker
  import rlsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  rlsc_in_if                    in_ch,
  rlsc_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  cfg_t        regs_now;
  logic        prev_left;
  logic        prev_right;
  logic        flash_bright;
  logic [31:0] left_press;
  logic [31:0] right_press;
  logic [31:0] pulse_start;
  logic [31:0] flash_start;
  mode_t       turn;
  result_t     expected_duties[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic void toggle_turn(input mode_t side, input logic [31:0] now);
    if (turn == side) begin
      turn = MODE_OFF;
    end else begin
      turn = side;
      flash_start = now;
      flash_bright = 1'b1;
    end
  endfunction

  function automatic logic [DUTY_W-1:0] lamp_level(input mode_t side, input logic brake,
                                                   input logic pulse);
    if (turn == side) return flash_bright ? regs_now.duty_full : '0;
    if (brake) return regs_now.duty_full;
    if (pulse) return regs_now.duty_half;
    return '0;
  endfunction

  function automatic result_t predict_lamps(input logic [31:0] now, input switches_t sw);
    logic        lb;
    logic        rb;
    logic        brake;
    logic        pulse;
    logic [31:0] pulse_age;
    result_t     r;
    lb = sw.read_ok & sw.left_button;
    rb = sw.read_ok & sw.right_button;
    brake = sw.read_ok & (sw.left_brake_on | sw.right_brake_on);
    // left side first, right side second
    if (lb && !prev_left && (now - left_press) > 32'(regs_now.lockout)) begin
      left_press = now;
      toggle_turn(MODE_LEFT, now);
    end
    prev_left = lb;
    if (rb && !prev_right && (now - right_press) > 32'(regs_now.lockout)) begin
      right_press = now;
      toggle_turn(MODE_RIGHT, now);
    end
    prev_right = rb;
    pulse_age = now - pulse_start;
    pulse = 1'b0;
    if (pulse_age < 32'(regs_now.pulse_on)) begin
      pulse = 1'b1;
    end else if (pulse_age >= 32'(regs_now.pulse_period)) begin
      pulse_start = now;
      pulse = 1'b1;
    end
    if (turn != MODE_OFF) pulse = 1'b0;
    // flasher keeps running with the signal off
    if ((now - flash_start) >= 32'(regs_now.flash_half)) begin
      flash_bright = !flash_bright;
      flash_start = now;
    end
    r.duty_left = lamp_level(MODE_LEFT, brake, pulse);
    r.duty_right = lamp_level(MODE_RIGHT, brake, pulse);
    r.brake_active = brake;
    r.signal_mode = turn;
    return r;
  endfunction

  always @(posedge clk) begin
    switches_t sw;
    result_t   want;
    if (!rst_n) begin
      fail_count = 0;
      regs_now.lockout = LOCKOUT_RST;
      regs_now.pulse_on = PULSE_ON_RST;
      regs_now.pulse_period = PULSE_PERIOD_RST;
      regs_now.flash_half = FLASH_HALF_RST;
      regs_now.duty_full = DUTY_FULL_RST;
      regs_now.duty_half = DUTY_HALF_RST;
      prev_left = 1'b0;
      prev_right = 1'b0;
      flash_bright = 1'b0;
      left_press = '0;
      right_press = '0;
      pulse_start = '0;
      flash_start = '0;
      turn = MODE_OFF;
      expected_duties.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_LOCKOUT:      regs_now.lockout = cfg_wdata;
          REG_PULSE_ON:     regs_now.pulse_on = cfg_wdata;
          REG_PULSE_PERIOD: regs_now.pulse_period = cfg_wdata;
          REG_FLASH_HALF:   regs_now.flash_half = cfg_wdata;
          REG_DUTY_FULL:    regs_now.duty_full = cfg_wdata[DUTY_W-1:0];
          REG_DUTY_HALF:    regs_now.duty_half = cfg_wdata[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        sw.read_ok = in_ch.read_ok;
        sw.left_button = in_ch.left_button;
        sw.right_button = in_ch.right_button;
        sw.left_brake_on = in_ch.left_brake_on;
        sw.right_brake_on = in_ch.right_brake_on;
        expected_duties.push_back(predict_lamps(in_ch.time_now, sw));
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_duties.size() == 0) begin
          report_mismatch("result with no request pending", 0, 0);
        end else begin
          want = expected_duties.pop_front();
          if (out_ch.duty_left !== want.duty_left)
            report_mismatch("duty_left", out_ch.duty_left, want.duty_left);
          if (out_ch.duty_right !== want.duty_right)
            report_mismatch("duty_right", out_ch.duty_right, want.duty_right);
          if (out_ch.brake_active !== want.brake_active)
            report_mismatch("brake_active", out_ch.brake_active, want.brake_active);
          if (out_ch.signal_mode !== want.signal_mode)
            report_mismatch("signal_mode", out_ch.signal_mode, want.signal_mode);
        end
      end
    end
    pending = expected_duties.size();
  end

endmodule

[test/rear_light_signal_controller_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rear_light_signal_controller_top_test
// Drives poll sample requests and register writes into the rear light signal
// controller and takes its duty results with random stalls. A short directed
// run at reset settings covers presses, lockout, both buttons at once, failed
// reads and time wrap; then phases of random samples run under extreme,
// zero and random register settings, two with a long receiver hold-off and
// two with no sender idling. The checker instance does all the comparing.
// ----------------------------------------------------------------------------
module rear_light_signal_controller_top_test;
  import rlsc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 60;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int          fail_count;
  int          pending;
  int          hold_reqs = 0;
  int          quiet = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  logic [31:0] tick;
  int          step_max;
  logic [15:0] reg_vals[6];

  rlsc_in_if  in_ch();
  rlsc_out_if out_ch();

  rear_light_signal_controller_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  rear_light_signal_controller_checker lamp_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // switch bits: read_ok, left, right, left brake, right brake
  task automatic send_sample(input logic [31:0] t, input switches_t sw);
    int gap;
    gap = pick_gap(send_calm);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.time_now <= t;
    in_ch.read_ok <= sw.read_ok;
    in_ch.left_button <= sw.left_button;
    in_ch.right_button <= sw.right_button;
    in_ch.left_brake_on <= sw.left_brake_on;
    in_ch.right_brake_on <= sw.right_brake_on;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config();
    for (int i = REG_LOCKOUT; i <= REG_DUTY_HALF; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= CFG_IDX_W'(i);
      cfg_wdata <= reg_vals[i];
      @(posedge clk);
    end
    // unmapped index, must be ignored
    cfg_addr <= CFG_IDX_W'(REG_DUTY_HALF + 1 + $urandom_range(0, 1));
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_samples(input int count);
    switches_t sw;
    sw = '0;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 3) tick = $urandom;
      else tick = tick + $urandom_range(0, step_max);
      sw.read_ok = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 2) == 0) sw.left_button = !sw.left_button;
      if ($urandom_range(0, 2) == 0) sw.right_button = !sw.right_button;
      if ($urandom_range(0, 3) == 0) sw.left_brake_on = !sw.left_brake_on;
      if ($urandom_range(0, 3) == 0) sw.right_brake_on = !sw.right_brake_on;
      send_sample(tick, sw);
    end
  endtask

  function automatic logic [15:0] pick_ticks(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'(lo);
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(lo, hi));
  endfunction

  // receiver side: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    static int stall_left = 0;
    static int hold_seen = 0;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      out_ch.ready <= 1'b0;
      stall_left = HOLD_OFF_CYCLES;
    end else if (!recv_calm && $urandom_range(0, 99) < 25) begin
      out_ch.ready <= 1'b0;
      stall_left = pick_gap(1'b0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.time_now = '0;
    in_ch.read_ok = 1'b0;
    in_ch.left_button = 1'b0;
    in_ch.right_button = 1'b0;
    in_ch.left_brake_on = 1'b0;
    in_ch.right_brake_on = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: lockout 50, pulse 10 of 1000, flash half 333
    send_sample(32'd0,          5'b10000);
    send_sample(32'd5,          5'b10011);
    send_sample(32'd100,        5'b11000);
    send_sample(32'd120,        5'b11000);
    send_sample(32'd130,        5'b10000);
    send_sample(32'd140,        5'b11000);
    send_sample(32'd141,        5'b10000);
    send_sample(32'd200,        5'b11000);
    send_sample(32'd201,        5'b10010);
    send_sample(32'd300,        5'b11100);
    send_sample(32'd301,        5'b01111);
    send_sample(32'd400,        5'b01111);
    send_sample(32'd700,        5'b10001);
    send_sample(32'd1000,       5'b10000);
    send_sample(32'd1005,       5'b10100);
    send_sample(32'd1006,       5'b10000);
    send_sample(32'hFFFF_FFF0,  5'b11111);
    send_sample(32'hFFFF_FFFF,  5'b10000);
    send_sample(32'h0000_0005,  5'b11000);
    send_sample(32'h0000_0100,  5'b10000);
    send_sample(32'hAAAA_5555,  5'b10100);
    send_sample(32'h5555_AAAA,  5'b10000);
    tick = 32'h5555_AAAA;

    for (int phase = 0; phase < 10; phase++) begin
      settle();
      send_calm = 1'b0;
      recv_calm = 1'b0;
      case (phase)
        0: begin
          reg_vals = '{16'd0, 16'd0, 16'd1, 16'd1, 16'h01FF, 16'd0};
          step_max = 3;
        end
        1: begin
          reg_vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd255};
          step_max = 40000;
        end
        2: begin
          reg_vals = '{16'($urandom_range(0, 40)), 16'($urandom_range(0, 30)),
                       16'($urandom_range(1, 100)), 16'($urandom_range(1, 50)),
                       16'($urandom), 16'($urandom)};
          step_max = 10;
          send_calm = 1'b1;
          hold_reqs++;
        end
        3: begin
          // zero period and zero flash half
          reg_vals = '{16'd5, 16'd2, 16'd0, 16'd0, 16'h0AB5, 16'h7F01};
          step_max = 5;
          send_calm = 1'b1;
          recv_calm = 1'b1;
        end
        default: begin
          reg_vals = '{pick_ticks(0, 200), pick_ticks(0, 100), pick_ticks(1, 400),
                       pick_ticks(1, 200), 16'($urandom), 16'($urandom)};
          step_max = $urandom_range(1, 200);
          if (phase == 7) hold_reqs++;
        end
      endcase
      load_config();
      random_samples(200);
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
